FILE: design/assert_macros.svh
// Assertion macros shared by the xorshift range random block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset is released.
`define XRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define XRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/xrr_pkg.sv
// Package for the xorshift range random block: types, constants, generator step.
// No dependencies.
package xrr_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 24;

  typedef logic [WordW-1:0] word_t;
  typedef logic [3:0][WordW-1:0] words_t;

  localparam logic [1:0] REQ_RESEED = 2'd0;
  localparam logic [1:0] REQ_RANGE  = 2'd1;
  localparam logic [1:0] REQ_UNIT   = 2'd2;

  localparam word_t WORD_MAX  = 32'hFFFF_FFFF;
  localparam word_t SEED_XOR1 = 32'h9e37_79b9;
  localparam word_t SEED_XOR3 = 32'h85eb_ca6b;
  localparam word_t LCG_MUL   = 32'd1664525;
  localparam word_t LCG_ADD   = 32'd1013904223;
  localparam int unsigned WarmupSteps = 16;

  localparam words_t RESET_WORDS = {32'hdead_beef, 32'hb7e1_5162,
                                    32'h243f_6a88, 32'h9e37_79b9};

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    logic  busy;
    word_t remainder;
  } div_rsp_t;

  function automatic words_t xrr_step(words_t w);
    word_t  t;
    word_t  s;
    words_t n;
    t    = w[3];
    s    = w[0];
    t    = t ^ (t << 11);
    t    = t ^ (t >> 8);
    n[3] = w[2];
    n[2] = w[1];
    n[1] = s;
    n[0] = t ^ s ^ (s >> 19);
    return n;
  endfunction

endpackage

FILE: design/xrr_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on xrr_pkg.
interface xrr_in_if;
  import xrr_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [WordW-1:0]   seed;
  logic signed [WordW-1:0] range_low;
  logic signed [WordW-1:0] range_high;

  modport source (output valid, output req_type, output seed, output range_low,
                  output range_high, input ready);
  modport sink   (input valid, input req_type, input seed, input range_low,
                  input range_high, output ready);
endinterface

interface xrr_out_if;
  import xrr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] value;
  logic [FracW-1:0]        unit_fraction;

  modport source (output valid, output value, output unit_fraction, input ready);
  modport sink   (input valid, input value, input unit_fraction, output ready);
endinterface

FILE: design/xorshift_range_random_top.sv
// Xorshift128 random source: reseed, uniform integer in range, 0.24 unit fraction.
// After acceptance: reseed loads the seed words and warms up the generator; unit and
// full span take one draw, equal bounds none; other ranges run the remainder unit for
// a rejection limit, draw until below it, then run it again for the result. One request
// at a time; ready returns as out_valid rises, or later while an old result is unaccepted.
// Synchronous active-low reset loads the fixed generator words and clears control.
`include "assert_macros.svh"

module xorshift_range_random_top (
  input logic      clk,
  input logic      rst_n,
  xrr_in_if.sink   in_chan,
  xrr_out_if.source out_chan
);
  import xrr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WARM = 4'd1;
  localparam logic [3:0] S_UNIT = 4'd2;
  localparam logic [3:0] S_SPAN = 4'd3;
  localparam logic [3:0] S_FULL = 4'd4;
  localparam logic [3:0] S_LIMW = 4'd5;
  localparam logic [3:0] S_DRAW = 4'd6;
  localparam logic [3:0] S_MODW = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]       state_r, state_nxt;
  words_t           words_r, words_nxt;
  logic [3:0]       warm_r, warm_nxt;
  word_t            lo_r, lo_nxt;
  word_t            hi_r, hi_nxt;
  word_t            span_r, span_nxt;
  word_t            limit_r, limit_nxt;
  word_t            res_val_r, res_val_nxt;
  logic [FracW-1:0] res_frac_r, res_frac_nxt;
  logic             out_valid_r, out_valid_nxt;
  word_t            out_val_r, out_val_nxt;
  logic [FracW-1:0] out_frac_r, out_frac_nxt;

  words_t   stepped;
  word_t    seed_eff;
  word_t    span_c;
  logic     accept;
  div_req_t div_req;
  div_rsp_t div_rsp;

  xrr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign stepped  = xrr_step(words_r);
  assign seed_eff = (in_chan.seed == '0) ? word_t'(1) : in_chan.seed;
  assign span_c   = hi_r - lo_r + word_t'(1);
  assign accept   = in_chan.valid && in_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    words_nxt     = words_r;
    warm_nxt      = warm_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    span_nxt      = span_r;
    limit_nxt     = limit_r;
    res_val_nxt   = res_val_r;
    res_frac_nxt  = res_frac_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_val_nxt   = out_val_r;
    out_frac_nxt  = out_frac_r;
    div_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_val_nxt  = '0;
          res_frac_nxt = '0;
          unique case (in_chan.req_type)
            REQ_RESEED: begin
              words_nxt[0] = seed_eff;
              words_nxt[1] = seed_eff ^ SEED_XOR1;
              words_nxt[2] = seed_eff * LCG_MUL + LCG_ADD;
              words_nxt[3] = seed_eff ^ SEED_XOR3;
              warm_nxt     = 4'(WarmupSteps - 1);
              state_nxt    = S_WARM;
            end
            REQ_RANGE: begin
              if (in_chan.range_high < in_chan.range_low) begin
                lo_nxt = in_chan.range_high;
                hi_nxt = in_chan.range_low;
              end else begin
                lo_nxt = in_chan.range_low;
                hi_nxt = in_chan.range_high;
              end
              state_nxt = S_SPAN;
            end
            REQ_UNIT: state_nxt = S_UNIT;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_WARM: begin
        words_nxt = stepped;
        warm_nxt  = warm_r - 4'd1;
        if (warm_r == '0) state_nxt = S_DONE;
      end
      S_UNIT: begin
        words_nxt    = stepped;
        res_frac_nxt = stepped[0][WordW-1 -: FracW];
        state_nxt    = S_DONE;
      end
      S_SPAN: begin
        if (lo_r == hi_r) begin
          res_val_nxt = lo_r;
          state_nxt   = S_DONE;
        end else if (span_c == '0) begin
          state_nxt = S_FULL;
        end else begin
          span_nxt         = span_c;
          div_req.start    = 1'b1;
          div_req.dividend = WORD_MAX;
          div_req.divisor  = span_c;
          state_nxt        = S_LIMW;
        end
      end
      S_FULL: begin
        words_nxt   = stepped;
        res_val_nxt = stepped[0];
        state_nxt   = S_DONE;
      end
      S_LIMW: begin
        if (div_rsp.done) begin
          limit_nxt = WORD_MAX - div_rsp.remainder;
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        words_nxt = stepped;
        if (stepped[0] < limit_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = stepped[0];
          div_req.divisor  = span_r;
          state_nxt        = S_MODW;
        end
      end
      S_MODW: begin
        if (div_rsp.done) begin
          res_val_nxt = lo_r + div_rsp.remainder;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_frac_nxt  = res_frac_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    warm_r     <= warm_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    span_r     <= span_nxt;
    limit_r    <= limit_nxt;
    res_val_r  <= res_val_nxt;
    res_frac_r <= res_frac_nxt;
    out_val_r  <= out_val_nxt;
    out_frac_r <= out_frac_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      words_r     <= RESET_WORDS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      words_r     <= words_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.value         = out_val_r;
  assign out_chan.unit_fraction = out_frac_r;

  `XRR_ASSERT(a_words_nonzero, words_r != '0, "generator reached the all-zero state")
  `XRR_ASSERT(a_limit_covers_span, state_r == S_DRAW |-> limit_r >= span_r && limit_r != '0, "rejection limit below span")
  `XRR_ASSERT(a_div_done_waited, div_rsp.done |-> state_r == S_LIMW || state_r == S_MODW, "remainder beat with nobody waiting")
  `XRR_ASSERT(a_div_idle_on_start, div_req.start |-> !div_rsp.busy, "remainder unit started while busy")
endmodule

FILE: design/xrr_div.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on xrr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xrr_div (
  input  logic             clk,
  input  logic             rst_n,
  input  xrr_pkg::div_req_t req,
  output xrr_pkg::div_rsp_t rsp
);
  import xrr_pkg::*;

  logic [WordW:0] rem_r, rem_nxt;
  word_t          dvd_r, dvd_nxt;
  word_t          dsr_r, dsr_nxt;
  logic [4:0]     cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [WordW:0] rem_sh;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[WordW-1:0], dvd_r[WordW-1]};
    if (busy_r) begin
      rem_nxt = (rem_sh >= {1'b0, dsr_r}) ? rem_sh - {1'b0, dsr_r} : rem_sh;
      dvd_nxt = {dvd_r[WordW-2:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = 5'd31;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.busy      = busy_r;
  assign rsp.remainder = rem_r[WordW-1:0];

  `XRR_ASSERT(a_rem_below_divisor, busy_r |-> rem_r < {1'b0, dsr_r}, "partial remainder not below divisor")
  `XRR_ASSERT(a_done_after_busy, done_r |-> $past(busy_r) && !busy_r, "done without a finished run")
endmodule

FILE: sim/xorshift_range_random_top_test.sv
// Self-checking test of xorshift_range_random_top: reseed, range and unit requests,
// each answer checked against an in-bench xorshift128 generator.
// Depends on xrr_pkg and the xrr_in_if / xrr_out_if interfaces.
module xorshift_range_random_top_test;
  import xrr_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam word_t      INT_MIN    = 32'h8000_0000;
  localparam word_t      INT_MAX    = 32'h7fff_ffff;
  localparam int unsigned RandomItems = 1580;

  typedef struct packed {
    word_t            value;
    logic [FracW-1:0] frac;
  } answer_t;

  typedef enum int unsigned {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_BLOCKS} sink_mode_t;

  logic clk;
  logic rst_n;

  xrr_in_if  req_bus ();
  xrr_out_if ans_bus ();

  xorshift_range_random_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_bus),
    .out_chan (ans_bus)
  );

  words_t      gen_state;
  answer_t     awaited_answers[$];
  int unsigned mismatch_count;
  int unsigned burst_left;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generator mirror
  function automatic word_t advance_gen();
    word_t t;
    word_t s;
    t = gen_state[3];
    s = gen_state[0];
    t ^= t << 11;
    t ^= t >> 8;
    gen_state[3] = gen_state[2];
    gen_state[2] = gen_state[1];
    gen_state[1] = s;
    gen_state[0] = t ^ s ^ (s >> 19);
    return gen_state[0];
  endfunction

  function automatic void reseed_gen(input word_t seed_w);
    word_t sd;
    sd = (seed_w == '0) ? word_t'(1) : seed_w;
    gen_state[0] = sd;
    gen_state[1] = sd ^ SEED_XOR1;
    gen_state[2] = sd * LCG_MUL + LCG_ADD;
    gen_state[3] = sd ^ SEED_XOR3;
    repeat (WarmupSteps) void'(advance_gen());
  endfunction

  // Uniform pick in [lo, hi] with rejection at or above the largest multiple of the span
  function automatic word_t pick_in_range(input word_t lo, input word_t hi);
    word_t a;
    word_t b;
    word_t span;
    word_t ceiling;
    word_t r;
    a = lo;
    b = hi;
    if ($signed(b) < $signed(a)) begin
      a = hi;
      b = lo;
    end
    if (a == b) return a;
    span = b - a + 32'd1;
    if (span == '0) return advance_gen();
    ceiling = (WORD_MAX / span) * span;
    do r = advance_gen(); while (r >= ceiling);
    return a + r % span;
  endfunction

  function automatic answer_t draw_answer(input logic [1:0] kind, input word_t seed_w,
                                          input word_t lo, input word_t hi);
    answer_t ans;
    word_t   w;
    ans = '0;
    case (kind)
      REQ_RESEED: reseed_gen(seed_w);
      REQ_RANGE:  ans.value = pick_in_range(lo, hi);
      REQ_UNIT: begin
        w = advance_gen();
        ans.frac = w[31:8];
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Request beats, in bursts with random gaps
  task automatic send_request(input logic [1:0] kind, input word_t seed_w,
                              input word_t lo, input word_t hi);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        req_bus.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= kind;
    req_bus.seed       <= seed_w;
    req_bus.range_low  <= lo;
    req_bus.range_high <= hi;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    awaited_answers.push_back(draw_answer(kind, seed_w, lo, hi));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern, switched at random among open, coin, periodic and block modes
  int unsigned sink_cycle;
  int unsigned sink_hold;
  sink_mode_t  sink_mode;

  always @(negedge clk) begin
    if (sink_cycle % 64 == 0) sink_mode = sink_mode_t'($urandom_range(0, 3));
    sink_cycle++;
    case (sink_mode)
      SINK_OPEN:     ans_bus.ready <= 1'b1;
      SINK_COIN:     ans_bus.ready <= ($urandom_range(0, 1) == 1);
      SINK_PERIODIC: ans_bus.ready <= (sink_cycle % 4 == 0);
      default: begin
        if (sink_hold > 0) begin
          sink_hold--;
          ans_bus.ready <= 1'b0;
        end else begin
          sink_hold = $urandom_range(0, 12);
          ans_bus.ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin : check_answers
    answer_t want;
    if (rst_n && ans_bus.valid && ans_bus.ready) begin
      if (awaited_answers.size() == 0) begin
        $error("result beat with nothing outstanding: value %0d unit_fraction %0h",
               ans_bus.value, ans_bus.unit_fraction);
        mismatch_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (ans_bus.value !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), ans_bus.value);
          mismatch_count++;
        end
        if (ans_bus.unit_fraction !== want.frac) begin
          $error("unit_fraction: expected %0h, got %0h", want.frac, ans_bus.unit_fraction);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_reset_sequence();
    send_request(REQ_UNIT, '0, '0, '0);
    send_request(REQ_UNIT, '0, '0, '0);
    send_request(REQ_RANGE, '0, word_t'(-10), 32'd10);
  endtask

  task automatic test_range_bounds();
    send_request(REQ_RANGE, '0, INT_MIN, INT_MIN);
    send_request(REQ_RANGE, '0, INT_MAX, INT_MAX);
    send_request(REQ_RANGE, '0, 32'd100, word_t'(-100));
    send_request(REQ_RANGE, '0, INT_MIN, INT_MAX);
    send_request(REQ_RANGE, '0, INT_MAX, INT_MIN);
    send_request(REQ_RANGE, '0, INT_MIN, 32'd0);
    send_request(REQ_RANGE, '0, 32'hffff_ffff, INT_MAX);
    send_request(REQ_RANGE, '0, INT_MIN, INT_MAX - 32'd1);
    send_request(REQ_RANGE, '0, 32'd0, 32'd1);
    send_request(REQ_RANGE, '0, INT_MAX - 32'd1, INT_MAX);
  endtask

  task automatic test_reseed();
    send_request(REQ_RESEED, '0, '0, '0);
    send_request(REQ_UNIT, '0, '0, '0);
    send_request(REQ_RESEED, 32'd1, INT_MAX, INT_MIN);
    send_request(REQ_UNIT, '0, '0, '0);
    send_request(REQ_RESEED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_request(REQ_UNIT, '0, '0, '0);
    send_request(REQ_RANGE, 32'hffff_ffff, word_t'(-1000), 32'd1000);
  endtask

  task automatic test_unused_request();
    send_request(REQ_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_request(REQ_UNIT, '0, '0, '0);
  endtask

  task automatic test_random_mix();
    int unsigned sel;
    logic [1:0]  kind;
    word_t       seed_w;
    word_t       lo;
    word_t       hi;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      sel    = $urandom_range(0, 99);
      seed_w = $urandom;
      lo     = $urandom;
      hi     = $urandom;
      if (sel < 8) begin
        kind = REQ_RESEED;
        if ($urandom_range(0, 7) == 0) seed_w = '0;
      end else if (sel < 55) begin
        kind = REQ_RANGE;
        case ($urandom_range(0, 5))
          0: hi = lo + word_t'($urandom_range(0, 15));
          1: ;
          2: hi = lo;
          3: begin
            lo = INT_MIN;
            hi = INT_MAX;
          end
          4: begin
            lo = INT_MIN + word_t'($urandom_range(0, 255));
            hi = lo + INT_MIN;
          end
          default: begin
            lo = word_t'($urandom_range(0, 200)) - 32'd100;
            hi = word_t'($urandom_range(0, 200)) - 32'd100;
          end
        endcase
        if ($urandom_range(0, 1) == 1) {lo, hi} = {hi, lo};
      end else if (sel < 94) begin
        kind = REQ_UNIT;
      end else begin
        kind = REQ_UNUSED;
      end
      send_request(kind, seed_w, lo, hi);
      if (n % 250 == 249) wait_drained();
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_RESEED;
    req_bus.seed       = '0;
    req_bus.range_low  = '0;
    req_bus.range_high = '0;
    ans_bus.ready      = 1'b0;
    gen_state          = RESET_WORDS;
    mismatch_count     = 0;
    burst_left         = 0;
    sink_cycle         = 0;
    sink_hold          = 0;
    sink_mode          = SINK_OPEN;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_sequence();
    test_range_bounds();
    wait_drained();
    test_reseed();
    test_unused_request();
    wait_drained();
    test_random_mix();

    wait_drained();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/xrr_pkg.sv
design/xrr_if.sv
design/xrr_div.sv
design/xorshift_range_random_top.sv
sim/xorshift_range_random_top_test.sv
